// File: rtl/core/drrip_pkg.sv
// Shared types and constants for the DRRIP dead-block replacement unit.
// Used by the front decoder, the command queue, the back engine and the top level.
package drrip_pkg;

	localparam int SET_IN_W   = 11;
	localparam int WAY_IN_W   = 4;
	localparam int MASK_W     = 16;
	localparam int CHANCE_W   = 5;
	localparam int OP_W       = 2;
	localparam int PSEL_OUT_W = 10;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 16;

	localparam logic [1:0] RRPV_MAX = 2'd3;
	localparam logic [1:0] DEAD_MAX = 2'd3;
	localparam logic [1:0] RRPV_NEAR = 2'd2;

	typedef enum logic [OP_W-1:0] {
		OP_QUERY  = 2'd0,
		OP_UPDATE = 2'd1,
		OP_DECAY  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_DECAY,
		ST_DECAY_LAST,
		ST_FINISH
	} back_state_t;

	// Decoded command handed from the front to the back
	typedef struct packed {
		op_t                 op;
		logic [SET_IN_W-1:0] set_idx;
		logic [WAY_IN_W-1:0] way;
		logic                way_ok;
		logic                hit;
		logic                leader;
		logic                brrip_leader;
		logic                inv_found;
		logic [WAY_IN_W-1:0] inv_way;
		logic                chance_zero;
	} cmd_t;

	typedef struct packed {
		logic clearing;
		logic pop;
		logic out_load;
	} back_status_t;

endpackage

// File: rtl/core/drrip_front.sv
// Front decoder: wraps the set index, classifies leader sets and finds the first invalid way.
// Depends on drrip_pkg.
module drrip_front #(
	parameter int SETS        = 2048,
	parameter int WAYS        = 16,
	parameter int LEADER_SETS = 64
) (
	input  drrip_pkg::op_t                        opcode,
	input  logic [drrip_pkg::SET_IN_W-1:0]        set_index,
	input  logic [drrip_pkg::WAY_IN_W-1:0]        way_index,
	input  logic                                  hit,
	input  logic [drrip_pkg::MASK_W-1:0]          valid_mask,
	input  logic [drrip_pkg::CHANCE_W-1:0]        chance,
	output drrip_pkg::cmd_t                       cmd
);

	localparam int RED_W   = 21;
	localparam int RED_STEPS = 5;

	logic [RED_W-1:0] red;

	always_comb begin
		red = RED_W'(set_index);
		// index < 2048 and SETS >= 64, so quotient fits in five bits
		for (int k = RED_STEPS - 1; k >= 0; k--) begin
			if (red >= (RED_W'(SETS) << k)) begin
				red = red - (RED_W'(SETS) << k);
			end
		end
	end

	always_comb begin
		cmd.op           = opcode;
		cmd.set_idx      = red[drrip_pkg::SET_IN_W-1:0];
		cmd.way          = way_index;
		cmd.way_ok       = 6'(way_index) < 6'(WAYS);
		cmd.hit          = hit;
		cmd.leader       = red < RED_W'(LEADER_SETS);
		cmd.brrip_leader = (red < RED_W'(LEADER_SETS)) && (red >= RED_W'(LEADER_SETS / 2));
		cmd.chance_zero  = (chance == '0);
		cmd.inv_found    = 1'b0;
		cmd.inv_way      = '0;
		// ways at or above the mask width count as valid
		for (int w = drrip_pkg::MASK_W - 1; w >= 0; w--) begin
			if (w < WAYS && !valid_mask[w]) begin
				cmd.inv_found = 1'b1;
				cmd.inv_way   = drrip_pkg::WAY_IN_W'(w);
			end
		end
	end

endmodule

// File: rtl/core/drrip_cmd_fifo.sv
// Two-entry command queue between the front decoder and the back engine.
// Depends on drrip_pkg.
module drrip_cmd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  drrip_pkg::cmd_t cmd_in,
	input  logic            pop,
	output drrip_pkg::cmd_t cmd_out,
	output logic            full,
	output logic            empty
);

	drrip_pkg::cmd_t entry_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign cmd_out = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

// File: rtl/core/drrip_back.sv
// Back engine: set-row memory, query/update read-modify-write, decay sweep, clearing pass,
// policy selector and result register. Depends on drrip_pkg.
module drrip_back #(
	parameter int SETS     = 2048,
	parameter int WAYS     = 16,
	parameter int SEL_BITS = 10
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  drrip_pkg::cmd_t                       cmd_head,
	input  logic                                  q_empty,
	output drrip_pkg::back_status_t               status,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [drrip_pkg::WAY_IN_W-1:0]        out_victim,
	output logic [drrip_pkg::PSEL_OUT_W-1:0]      out_psel
);

	localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int HALF_W = 2 * WAYS;
	localparam int ROW_W = 4 * WAYS;
	localparam logic [SET_W-1:0] LAST_SET = SET_W'(SETS - 1);
	localparam logic [SEL_BITS-1:0] SEL_MID = SEL_BITS'(1) << (SEL_BITS - 1);
	localparam logic [SEL_BITS-1:0] SEL_TOP = '1;
	localparam logic [ROW_W-1:0] CLEAR_ROW = {{HALF_W{1'b0}}, {HALF_W{1'b1}}};

	// row layout: RRPV fields in the low half, dead counters in the high half
	logic [ROW_W-1:0] mem [SETS];

	drrip_pkg::back_state_t state_q, state_d;
	logic [SET_W-1:0]    cnt_q, cnt_d;
	drrip_pkg::cmd_t     cmd_q;
	logic                cmd_ld;
	logic [ROW_W-1:0]    rd_data_q;
	logic                rd_en;
	logic [SET_W-1:0]    rd_addr;
	logic                we;
	logic [SET_W-1:0]    wr_addr;
	logic [ROW_W-1:0]    wr_data;
	logic                pend_s1, pend_d;
	logic [SET_W-1:0]    pend_addr_s1;
	logic [SEL_BITS-1:0] psel_q, psel_d;
	logic                out_valid_q;
	logic [drrip_pkg::WAY_IN_W-1:0]   out_victim_q;
	logic [drrip_pkg::PSEL_OUT_W-1:0] out_psel_q;
	logic                load;
	logic [drrip_pkg::WAY_IN_W-1:0]   load_victim;
	logic                out_free;

	// datapath results
	logic [1:0]          rrpv [WAYS];
	logic [1:0]          dead [WAYS];
	logic [ROW_W-1:0]    q_row;
	logic [drrip_pkg::WAY_IN_W-1:0] q_victim;
	logic [ROW_W-1:0]    u_row;
	logic [SEL_BITS-1:0] u_psel;
	logic [ROW_W-1:0]    dec_row;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			rrpv[w] = rd_data_q[2*w +: 2];
			dead[w] = rd_data_q[HALF_W + 2*w +: 2];
		end
	end

	// victim query
	always_comb begin
		logic                dm_found;
		logic [WAY_W-1:0]    dm_way;
		logic [1:0]          top;
		logic [1:0]          add;
		logic [WAY_W-1:0]    age_way;
		logic                any3, any2, any1;
		dm_found = 1'b0;
		dm_way   = '0;
		age_way  = '0;
		any3 = 1'b0;
		any2 = 1'b0;
		any1 = 1'b0;
		for (int w = 0; w < WAYS; w++) begin
			any3 |= (rrpv[w] == 2'd3);
			any2 |= (rrpv[w] == 2'd2);
			any1 |= (rrpv[w] == 2'd1);
		end
		top = any3 ? 2'd3 : (any2 ? 2'd2 : (any1 ? 2'd1 : 2'd0));
		add = drrip_pkg::RRPV_MAX - top;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (rrpv[w] == drrip_pkg::RRPV_MAX && dead[w] == drrip_pkg::DEAD_MAX) begin
				dm_found = 1'b1;
				dm_way   = WAY_W'(w);
			end
			if (rrpv[w] == top) begin
				age_way = WAY_W'(w);
			end
		end
		q_row = rd_data_q;
		if (cmd_q.inv_found) begin
			q_victim = cmd_q.inv_way;
		end else if (dm_found) begin
			q_victim = drrip_pkg::WAY_IN_W'(dm_way);
		end else begin
			q_victim = drrip_pkg::WAY_IN_W'(age_way);
			for (int w = 0; w < WAYS; w++) begin
				q_row[2*w +: 2] = rrpv[w] + add;
			end
		end
	end

	// update after access
	always_comb begin
		logic [WAY_W-1:0] widx;
		logic [1:0]       d;
		logic [1:0]       bdepth;
		logic [1:0]       ins;
		widx   = WAY_W'(cmd_q.way);
		d      = dead[widx];
		bdepth = cmd_q.chance_zero ? drrip_pkg::RRPV_NEAR : drrip_pkg::RRPV_MAX;
		ins    = drrip_pkg::RRPV_MAX;
		u_row  = rd_data_q;
		u_psel = psel_q;
		if (cmd_q.hit) begin
			u_row[2*widx +: 2]          = 2'd0;
			u_row[HALF_W + 2*widx +: 2] = 2'd0;
			if (cmd_q.leader && !cmd_q.brrip_leader && psel_q != SEL_TOP) begin
				u_psel = psel_q + 1'b1;
			end else if (cmd_q.brrip_leader && psel_q != '0) begin
				u_psel = psel_q - 1'b1;
			end
		end else begin
			if (d != drrip_pkg::DEAD_MAX) begin
				d = d + 2'd1;
			end
			if (cmd_q.leader) begin
				ins = cmd_q.brrip_leader ? bdepth : drrip_pkg::RRPV_NEAR;
			end else begin
				ins = (psel_q >= SEL_MID) ? drrip_pkg::RRPV_NEAR : bdepth;
			end
			if (d == drrip_pkg::DEAD_MAX) begin
				ins = drrip_pkg::RRPV_MAX;
			end
			u_row[2*widx +: 2]          = ins;
			u_row[HALF_W + 2*widx +: 2] = d;
		end
	end

	// decay of one row
	always_comb begin
		dec_row = rd_data_q;
		for (int w = 0; w < WAYS; w++) begin
			if (dead[w] != 2'd0) begin
				dec_row[HALF_W + 2*w +: 2] = dead[w] - 2'd1;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		cmd_ld      = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = SET_W'(cmd_head.set_idx);
		we          = 1'b0;
		wr_addr     = SET_W'(cmd_q.set_idx);
		wr_data     = q_row;
		pend_d      = 1'b0;
		psel_d      = psel_q;
		load        = 1'b0;
		load_victim = '0;
		status.pop  = 1'b0;
		unique case (state_q)
			drrip_pkg::ST_CLEAR: begin
				we      = 1'b1;
				wr_addr = cnt_q;
				wr_data = CLEAR_ROW;
				cnt_d   = cnt_q + 1'b1;
				if (cnt_q == LAST_SET) begin
					cnt_d   = '0;
					state_d = drrip_pkg::ST_IDLE;
				end
			end
			drrip_pkg::ST_IDLE: begin
				if (!q_empty) begin
					status.pop = 1'b1;
					cmd_ld     = 1'b1;
					unique case (cmd_head.op)
						drrip_pkg::OP_QUERY: begin
							rd_en   = 1'b1;
							state_d = drrip_pkg::ST_EXEC;
						end
						drrip_pkg::OP_UPDATE: begin
							rd_en   = cmd_head.way_ok;
							state_d = cmd_head.way_ok ? drrip_pkg::ST_EXEC
								: drrip_pkg::ST_FINISH;
						end
						drrip_pkg::OP_DECAY: begin
							cnt_d   = '0;
							state_d = drrip_pkg::ST_DECAY;
						end
						drrip_pkg::OP_NONE: begin
							state_d = drrip_pkg::ST_FINISH;
						end
					endcase
				end
			end
			drrip_pkg::ST_EXEC: begin
				if (out_free) begin
					we   = 1'b1;
					load = 1'b1;
					if (cmd_q.op == drrip_pkg::OP_QUERY) begin
						wr_data     = q_row;
						load_victim = q_victim;
					end else begin
						wr_data = u_row;
						psel_d  = u_psel;
					end
					state_d = drrip_pkg::ST_IDLE;
				end
			end
			drrip_pkg::ST_DECAY: begin
				// read row n while writing back row n-1
				rd_en   = 1'b1;
				rd_addr = cnt_q;
				we      = pend_s1;
				wr_addr = pend_addr_s1;
				wr_data = dec_row;
				pend_d  = 1'b1;
				cnt_d   = cnt_q + 1'b1;
				if (cnt_q == LAST_SET) begin
					state_d = drrip_pkg::ST_DECAY_LAST;
				end
			end
			drrip_pkg::ST_DECAY_LAST: begin
				we      = 1'b1;
				wr_addr = pend_addr_s1;
				wr_data = dec_row;
				state_d = drrip_pkg::ST_FINISH;
			end
			drrip_pkg::ST_FINISH: begin
				if (out_free) begin
					load    = 1'b1;
					state_d = drrip_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = drrip_pkg::ST_IDLE;
			end
		endcase
		status.clearing = (state_q == drrip_pkg::ST_CLEAR);
		status.out_load = load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= drrip_pkg::ST_CLEAR;
			cnt_q       <= '0;
			pend_s1     <= 1'b0;
			psel_q      <= SEL_MID;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pend_s1 <= pend_d;
			psel_q  <= psel_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pend_addr_s1 <= cnt_q;
		if (cmd_ld) begin
			cmd_q <= cmd_head;
		end
		if (load) begin
			out_victim_q <= load_victim;
			out_psel_q   <= drrip_pkg::PSEL_OUT_W'(psel_d);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign out_valid  = out_valid_q;
	assign out_victim = out_victim_q;
	assign out_psel   = out_psel_q;

endmodule

// File: rtl/core/drrip_dead_block_replacement_unit.sv
// Query/update: result loaded after the queue pop with row read, then modify/write (held while the
// result slot is full); the next command is popped only after the read-modify-write of one row in the set-row memory.
// Decay: a sweep over every row, one row read and one row written back per cycle.
// Reset: asynchronous; a clearing pass writes every row (RRPV 3, dead 0)
// while input is not ready; the policy selector resets to its midpoint.
// Top level: stream ports, front decoder, command queue, back engine. Depends on drrip_pkg.
module drrip_dead_block_replacement_unit #(
	parameter int SETS        = 2048,
	parameter int WAYS        = 16,
	parameter int LEADER_SETS = 64,
	parameter int SEL_BITS    = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// set_index[10:0], way_index[14:11], hit[15], valid_mask[31:16], chance[36:32]
	input  logic [drrip_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// opcode[1:0]
	input  logic [drrip_pkg::OP_W-1:0]           s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// victim_way[3:0], psel_value[13:4]
	output logic [drrip_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

	drrip_pkg::cmd_t         cmd_front;
	drrip_pkg::cmd_t         cmd_head;
	drrip_pkg::back_status_t status;
	logic                    q_full;
	logic                    q_empty;
	logic                    push;
	logic [drrip_pkg::WAY_IN_W-1:0]   victim_way;
	logic [drrip_pkg::PSEL_OUT_W-1:0] psel_value;

	assign s_axis_tready = !q_full && !status.clearing;
	assign push          = s_axis_tvalid && s_axis_tready;

	drrip_front #(
		.SETS        (SETS),
		.WAYS        (WAYS),
		.LEADER_SETS (LEADER_SETS)
	) u_front (
		.opcode     (drrip_pkg::op_t'(s_axis_tuser)),
		.set_index  (s_axis_tdata[10:0]),
		.way_index  (s_axis_tdata[14:11]),
		.hit        (s_axis_tdata[15]),
		.valid_mask (s_axis_tdata[31:16]),
		.chance     (s_axis_tdata[36:32]),
		.cmd        (cmd_front)
	);

	drrip_cmd_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.cmd_in  (cmd_front),
		.pop     (status.pop),
		.cmd_out (cmd_head),
		.full    (q_full),
		.empty   (q_empty)
	);

	drrip_back #(
		.SETS     (SETS),
		.WAYS     (WAYS),
		.SEL_BITS (SEL_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_head   (cmd_head),
		.q_empty    (q_empty),
		.status     (status),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_victim (victim_way),
		.out_psel   (psel_value)
	);

	assign m_axis_tdata = {2'b00, psel_value, victim_way};

	// nothing is queued or delivered while the rows are being cleared
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		status.clearing |-> (!m_axis_tvalid && q_empty))
		else $error("activity during clearing pass");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		status.pop |-> !q_empty)
		else $error("command popped from empty queue");

	a_load_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(status.out_load && m_axis_tvalid) |-> m_axis_tready)
		else $error("result register overwritten before transaction");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push)
		else $error("command queue overflow");

endmodule

// File: bench/tb_drrip_dead_block_replacement_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for drrip_dead_block_replacement_unit: queued accesses, a clocked
// driver and monitor, and an in-bench replacement predictor. Depends on drrip_pkg.
module tb_drrip_dead_block_replacement_unit;

	localparam int NUM_SETS    = 2048;
	localparam int NUM_WAYS    = 16;
	localparam int LEADERS     = 64;
	localparam logic [9:0] SEL_MID = 10'd512;
	localparam logic [9:0] SEL_TOP = 10'h3FF;
	localparam int N_RANDOM    = 1130;
	localparam int SWING_AT    = 660;   // selector steering turns around here
	localparam int MAX_DECAYS  = 25;
	localparam int CALM_TAIL   = 150;
	localparam int HOLD_AT     = 260;
	localparam int HOLD_LEN    = 400;
	localparam int DRAIN       = 12;
	localparam int CYCLE_LIMIT = 500000;

	typedef struct {
		drrip_pkg::op_t op;
		logic [10:0] set_idx;
		logic [3:0]  way;
		logic        hit;
		logic [15:0] mask;
		logic [4:0]  chance;
	} access_t;

	typedef struct {
		logic [3:0] victim;
		logic [9:0] sel;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [drrip_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
	logic [drrip_pkg::OP_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [drrip_pkg::OUT_DATA_W-1:0] m_axis_tdata;

	drrip_dead_block_replacement_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	access_t access_q[$];
	reply_t  reply_q[$];
	access_t in_flight;

	// predictor state: 2 bits per way in each row
	logic [31:0] rrpv_tab [NUM_SETS];
	logic [31:0] dead_tab [NUM_SETS];
	logic [9:0]  sel_ctr;

	int n_total = 0;
	int n_acc = 0;
	int n_err = 0;
	int n_cycles = 0;
	int src_gap = 0;
	int sink_gap = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [3:0] pick_victim(int unsigned s, logic [15:0] mask);
		logic [1:0] top;
		top = 2'd0;
		for (int w = 0; w < NUM_WAYS; w++)
			if (!mask[w]) return 4'(w);
		for (int w = 0; w < NUM_WAYS; w++)
			if (rrpv_tab[s][2*w +: 2] == drrip_pkg::RRPV_MAX &&
					dead_tab[s][2*w +: 2] == drrip_pkg::DEAD_MAX)
				return 4'(w);
		for (int w = 0; w < NUM_WAYS; w++)
			if (rrpv_tab[s][2*w +: 2] > top) top = rrpv_tab[s][2*w +: 2];
		// age the whole set so the oldest way lands on the max RRPV
		if (top < drrip_pkg::RRPV_MAX)
			for (int w = 0; w < NUM_WAYS; w++)
				rrpv_tab[s][2*w +: 2] = rrpv_tab[s][2*w +: 2] + (drrip_pkg::RRPV_MAX - top);
		for (int w = 0; w < NUM_WAYS; w++)
			if (rrpv_tab[s][2*w +: 2] == drrip_pkg::RRPV_MAX) return 4'(w);
		return 4'd0;
	endfunction

	function automatic void touch_line(int unsigned s, int unsigned w, logic hit,
			logic [4:0] chance);
		logic leader;
		logic brrip_side;
		logic [1:0] cnt;
		logic [1:0] depth;
		logic [1:0] brrip_depth;
		leader = s < LEADERS;
		brrip_side = leader && s >= LEADERS / 2;
		brrip_depth = (chance == 5'd0) ? drrip_pkg::RRPV_NEAR : drrip_pkg::RRPV_MAX;
		if (hit) begin
			dead_tab[s][2*w +: 2] = 2'd0;
			rrpv_tab[s][2*w +: 2] = 2'd0;
			if (leader && !brrip_side && sel_ctr != SEL_TOP) sel_ctr = sel_ctr + 10'd1;
			if (leader && brrip_side && sel_ctr != 10'd0) sel_ctr = sel_ctr - 10'd1;
			return;
		end
		cnt = dead_tab[s][2*w +: 2];
		if (cnt != drrip_pkg::DEAD_MAX) cnt = cnt + 2'd1;
		dead_tab[s][2*w +: 2] = cnt;
		if (leader)
			depth = brrip_side ? brrip_depth : drrip_pkg::RRPV_NEAR;
		else
			depth = (sel_ctr >= SEL_MID) ? drrip_pkg::RRPV_NEAR : brrip_depth;
		if (cnt == drrip_pkg::DEAD_MAX) depth = drrip_pkg::RRPV_MAX;
		rrpv_tab[s][2*w +: 2] = depth;
	endfunction

	function automatic reply_t replace_step(access_t a);
		reply_t r;
		r.victim = 4'd0;
		case (a.op)
			drrip_pkg::OP_QUERY: r.victim = pick_victim(a.set_idx, a.mask);
			drrip_pkg::OP_UPDATE: touch_line(a.set_idx, a.way, a.hit, a.chance);
			drrip_pkg::OP_DECAY: begin
				for (int s = 0; s < NUM_SETS; s++)
					for (int w = 0; w < NUM_WAYS; w++)
						if (dead_tab[s][2*w +: 2] != 2'd0)
							dead_tab[s][2*w +: 2] = dead_tab[s][2*w +: 2] - 2'd1;
			end
			default: ;
		endcase
		r.sel = sel_ctr;
		return r;
	endfunction

	task automatic queue_access(drrip_pkg::op_t op, logic [10:0] s, logic [3:0] w, logic hit,
			logic [15:0] mask, logic [4:0] chance);
		access_t a;
		a.op = op;
		a.set_idx = s;
		a.way = w;
		a.hit = hit;
		a.mask = mask;
		a.chance = chance;
		access_q.push_back(a);
	endtask

	// mostly a handful of hot sets (both leader halves and followers) so state builds up
	function automatic logic [10:0] pool_set();
		case ($urandom_range(0, 9))
			0: return 11'd0;
			1: return 11'd31;
			2: return 11'd32;
			3: return 11'd63;
			4: return 11'd64;
			5: return 11'd1000;
			6: return 11'd2047;
			7: return 11'd17;
			default: return 11'($urandom_range(0, NUM_SETS - 1));
		endcase
	endfunction

	function automatic logic [3:0] hot_way();
		return ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
	endfunction

	// source side: one transaction in flight, random bursts of idle cycles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				reply_q.push_back(replace_step(in_flight));
				n_acc++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (access_q.size() != 0 && n_acc + CALM_TAIL < n_total &&
						(n_acc / 100) % 3 != 2 && $urandom_range(0, 4) == 0) begin
					src_gap = $urandom_range(1, 7) - 1;
					s_axis_tvalid <= 1'b0;
				end else if (access_q.size() != 0) begin
					in_flight = access_q.pop_front();
					s_axis_tdata <= {3'b000, in_flight.chance, in_flight.mask, in_flight.hit,
						in_flight.way, in_flight.set_idx};
					s_axis_tuser <= in_flight.op;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// sink side: checks each result transaction, stalls in bursts and once for a long stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (reply_q.size() == 0) begin
					n_err++;
					if (n_err <= 10)
						$display("ERROR: result %h with nothing outstanding", m_axis_tdata);
				end else begin
					reply_t exp_r;
					exp_r = reply_q.pop_front();
					if (m_axis_tdata[3:0] !== exp_r.victim || m_axis_tdata[13:4] !== exp_r.sel) begin
						n_err++;
						if (n_err <= 10)
							$display("ERROR: victim exp %0d got %0d, psel exp %0d got %0d",
								exp_r.victim, m_axis_tdata[3:0], exp_r.sel, m_axis_tdata[13:4]);
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (!hold_done && n_acc >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN - 1;
				m_axis_tready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				m_axis_tready <= 1'b0;
			end else if (n_acc + CALM_TAIL < n_total && (n_acc / 100) % 3 != 1 &&
					$urandom_range(0, 4) == 0) begin
				sink_gap = $urandom_range(1, 7) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		logic [10:0] s;
		logic [3:0] w;
		int kind;
		int seg;
		int n_steer;
		int n_rand;
		int n_decay;
		bit swung;

		for (int i = 0; i < NUM_SETS; i++) begin
			rrpv_tab[i] = '1;
			dead_tab[i] = '0;
		end
		sel_ctr = SEL_MID;

		// directed: invalid ways, dead path, aging, leader steering, insertion depths
		queue_access(drrip_pkg::OP_QUERY, 11'd0, 4'd0, 1'b0, 16'h0000, 5'd0);
		queue_access(drrip_pkg::OP_QUERY, 11'd5, 4'd0, 1'b0, 16'h7FFF, 5'd31);
		queue_access(drrip_pkg::OP_QUERY, 11'd2047, 4'd0, 1'b0, 16'hFFFF, 5'd0);
		queue_access(drrip_pkg::OP_UPDATE, 11'd2047, 4'd0, 1'b1, 16'h0000, 5'd0);
		queue_access(drrip_pkg::OP_QUERY, 11'd2047, 4'd0, 1'b0, 16'hFFFF, 5'd0);
		queue_access(drrip_pkg::OP_UPDATE, 11'd2047, 4'd5, 1'b0, 16'hFFFF, 5'd0);
		queue_access(drrip_pkg::OP_UPDATE, 11'd2047, 4'd5, 1'b0, 16'hFFFF, 5'd31);
		queue_access(drrip_pkg::OP_UPDATE, 11'd2047, 4'd5, 1'b0, 16'hFFFF, 5'd31);
		queue_access(drrip_pkg::OP_QUERY, 11'd2047, 4'd0, 1'b0, 16'hFFFF, 5'd0);
		queue_access(drrip_pkg::OP_UPDATE, 11'd0, 4'd3, 1'b1, 16'h0000, 5'd0);
		queue_access(drrip_pkg::OP_UPDATE, 11'd31, 4'd0, 1'b1, 16'h0000, 5'd0);
		queue_access(drrip_pkg::OP_UPDATE, 11'd32, 4'd1, 1'b1, 16'h0000, 5'd0);
		queue_access(drrip_pkg::OP_UPDATE, 11'd63, 4'd2, 1'b0, 16'h0000, 5'd0);
		queue_access(drrip_pkg::OP_UPDATE, 11'd63, 4'd3, 1'b0, 16'h0000, 5'd31);
		queue_access(drrip_pkg::OP_UPDATE, 11'd10, 4'd4, 1'b0, 16'h0000, 5'd17);
		queue_access(drrip_pkg::OP_UPDATE, 11'd100, 4'd6, 1'b0, 16'h0000, 5'd0);
		queue_access(drrip_pkg::OP_DECAY, 11'd0, 4'd0, 1'b0, 16'h0000, 5'd0);
		queue_access(drrip_pkg::OP_QUERY, 11'd2047, 4'd0, 1'b0, 16'hFFFF, 5'd0);
		queue_access(drrip_pkg::OP_NONE, 11'd1234, 4'd15, 1'b1, 16'hFFFF, 5'd31);
		queue_access(drrip_pkg::OP_DECAY, 11'd2047, 4'd15, 1'b1, 16'hFFFF, 5'd31);
		queue_access(drrip_pkg::OP_UPDATE, 11'd2047, 4'd5, 1'b0, 16'h0000, 5'd0);
		queue_access(drrip_pkg::OP_UPDATE, 11'd2047, 4'd15, 1'b1, 16'hFFFF, 5'd31);

		// random: selector pushed toward zero first, then back up; the rest is real traffic
		n_rand = 0;
		n_steer = 0;
		n_decay = 0;
		swung = 1'b0;
		while (n_rand < N_RANDOM) begin
			seg = (n_rand < SWING_AT) ? n_rand : n_rand - SWING_AT;
			if (n_rand >= SWING_AT && !swung) begin
				n_steer = 0;
				swung = 1'b1;
			end
			if ((n_rand < SWING_AT) ? (n_steer * 5 < seg * 4 + 1) : (n_steer * 2 < seg + 1)) begin
				s = (n_rand < SWING_AT) ? 11'($urandom_range(LEADERS / 2, LEADERS - 1))
					: 11'($urandom_range(0, LEADERS / 2 - 1));
				queue_access(drrip_pkg::OP_UPDATE, s, 4'($urandom_range(0, 15)), 1'b1,
					16'($urandom), 5'($urandom));
				n_steer++;
				n_rand++;
				continue;
			end
			kind = $urandom_range(0, 99);
			s = pool_set();
			w = hot_way();
			if (kind < 30) begin
				queue_access(drrip_pkg::OP_QUERY, s, 4'($urandom), 1'($urandom),
					($urandom_range(0, 9) < 7) ? 16'hFFFF
					: ($urandom_range(0, 2) != 0) ? ~(16'd1 << $urandom_range(0, 15))
					: 16'($urandom), 5'($urandom));
				n_rand++;
			end else if (kind < 55) begin
				queue_access(drrip_pkg::OP_UPDATE, s, w, $urandom_range(0, 9) < 4, 16'($urandom),
					($urandom_range(0, 1) != 0) ? 5'd0 : 5'($urandom));
				n_rand++;
			end else if (kind < 70) begin
				// touch every way, moving most off max RRPV, then query so aging can take place
				for (int i = 0; i < NUM_WAYS; i++)
					queue_access(drrip_pkg::OP_UPDATE, s, 4'(i), 1'($urandom_range(0, 1)),
						16'($urandom),
						($urandom_range(0, 3) == 0) ? 5'($urandom_range(1, 31)) : 5'd0);
				queue_access(drrip_pkg::OP_QUERY, s, 4'($urandom), 1'($urandom), 16'hFFFF,
					5'($urandom));
				n_rand += NUM_WAYS + 1;
			end else if (kind < 82) begin
				// three misses make the line dead, query finds it, then refill it
				for (int i = 0; i < 3; i++)
					queue_access(drrip_pkg::OP_UPDATE, s, w, 1'b0, 16'($urandom), 5'($urandom));
				queue_access(drrip_pkg::OP_QUERY, s, 4'($urandom), 1'($urandom), 16'hFFFF,
					5'($urandom));
				queue_access(drrip_pkg::OP_UPDATE, s, w, 1'b0, 16'($urandom), 5'($urandom));
				n_rand += 5;
			end else if (kind < 90 || (kind < 95 && n_decay >= MAX_DECAYS)) begin
				queue_access(drrip_pkg::OP_QUERY, s, 4'($urandom), 1'($urandom), 16'($urandom),
					5'($urandom));
				n_rand++;
			end else if (kind < 95) begin
				queue_access(drrip_pkg::OP_DECAY, 11'($urandom), 4'($urandom), 1'($urandom),
					16'($urandom), 5'($urandom));
				n_decay++;
				n_rand++;
			end else begin
				queue_access(drrip_pkg::OP_NONE, 11'($urandom), 4'($urandom), 1'($urandom),
					16'($urandom), 5'($urandom));
				n_rand++;
			end
		end
		n_total = access_q.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (n_acc < n_total || reply_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (n_err == 0 && reply_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
